// File: design/ntbw_pkg.sv
// ntbw_pkg: payload structs and fixed constants for nearest_three_bone_weights.
// No dependencies.
package ntbw_pkg;

  localparam int unsigned IdxBits   = 4;
  localparam int unsigned WgtBits   = 16;
  localparam int unsigned CntBits   = 5;
  localparam int unsigned CoordBits = 16;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef struct packed {
    logic                       cmd;
    logic [3:0]                 slot;
    logic signed [CoordBits-1:0] pos_x;
    logic signed [CoordBits-1:0] pos_y;
    logic signed [CoordBits-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic [IdxBits-1:0] idx_first;
    logic [IdxBits-1:0] idx_second;
    logic [IdxBits-1:0] idx_third;
    logic [WgtBits-1:0] weight_first;
    logic [WgtBits-1:0] weight_second;
    logic [WgtBits-1:0] weight_third;
    logic               status;
  } out_item_t;

endpackage

// File: design/ntbw_sqrt.sv
// ntbw_sqrt: iterative floor square root, one result bit per cycle.
// Depends on nothing.
module ntbw_sqrt #(
  parameter int unsigned InBits = 36
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [InBits-1:0]   val_i,
  output logic                done_o,
  output logic [InBits/2-1:0] root_o
);
  localparam int unsigned RBits = (InBits + 1) / 2;
  localparam int unsigned WBits = 2 * RBits;
  localparam int unsigned SBits = $clog2(RBits + 1);

  logic [WBits-1:0] v_q, v_d;
  logic [RBits-1:0] r_q, r_d;
  logic [RBits+1:0] rem_q, rem_d;
  logic [SBits-1:0] n_q, n_d;
  logic             busy_q, busy_d;
  logic [RBits+1:0] trial;
  logic [RBits+1:0] shifted;

  always_comb begin
    shifted = {rem_q[RBits-1:0], v_q[WBits-1 -: 2]};
    trial   = {r_q, 2'b01};
    v_d = v_q; r_d = r_q; rem_d = rem_q; n_d = n_q; busy_d = busy_q;
    if (start_i) begin
      v_d = WBits'(val_i); r_d = '0; rem_d = '0;
      n_d = SBits'(RBits); busy_d = 1'b1;
    end else if (busy_q) begin
      v_d = {v_q[WBits-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_d = shifted - trial;
        r_d = {r_q[RBits-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        r_d = {r_q[RBits-2:0], 1'b0};
      end
      n_d = n_q - 1'b1;
      if (n_q == SBits'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      n_q <= '0;
    end else begin
      busy_q <= busy_d;
      n_q <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d; r_q <= r_d; rem_q <= rem_d;
  end

  assign done_o = busy_q && (n_q == SBits'(1));
  assign root_o = r_d[InBits/2-1:0];
endmodule

// File: design/ntbw_frac.sv
// ntbw_frac: restoring fraction divider, floor(num*65536/den) saturated.
// Depends on nothing.
module ntbw_frac #(
  parameter int unsigned DBits = 38
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DBits-1:0] num_i,
  input  logic [DBits-1:0] den_i,
  output logic             done_o,
  output logic [15:0]      q_o
);
  logic [DBits:0]   r_q, r_d;
  logic [DBits-1:0] den_q, den_d;
  logic [15:0]      q_q, q_d;
  logic [4:0]       n_q, n_d;
  logic             busy_q, busy_d, sat_q, sat_d;
  logic [DBits:0]   sh;

  always_comb begin
    sh = {r_q[DBits-1:0], 1'b0};
    r_d = r_q; den_d = den_q; q_d = q_q; n_d = n_q; busy_d = busy_q; sat_d = sat_q;
    if (start_i) begin
      r_d = {1'b0, num_i}; den_d = den_i; q_d = '0; n_d = 5'd16; busy_d = 1'b1;
      sat_d = (den_i == '0) ? 1'b0 : (num_i >= den_i);
      if (den_i == '0) r_d = '0;
    end else if (busy_q) begin
      if (den_q != '0 && sh >= {1'b0, den_q}) begin
        r_d = sh - {1'b0, den_q};
        q_d = {q_q[14:0], 1'b1};
      end else begin
        r_d = (den_q == '0) ? '0 : sh;
        q_d = {q_q[14:0], 1'b0};
      end
      n_d = n_q - 1'b1;
      if (n_q == 5'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      n_q <= '0;
    end else begin
      busy_q <= busy_d;
      n_q <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d; den_q <= den_d; q_q <= q_d; sat_q <= sat_d;
  end

  assign done_o = busy_q && (n_q == 5'd1);
  assign q_o    = sat_q ? 16'hFFFF : q_d;
endmodule

// File: design/nearest_three_bone_weights.sv
// nearest_three_bone_weights: top level, handle table, distance scan and weight sequencer.
// Depends on ntbw_pkg, ntbw_sqrt and ntbw_frac.
//
// Loads write one handle position into the table and return no transaction. A query walks
// handles 0..min(handle_count, MAX_HANDLES)-1, each with a registered table read, then one
// shared squared-distance step with a three-deep sorted insert, then takes three floor square
// roots on one iterative root unit, forms the pair products with one multiplier when three
// handles are kept, and divides out up to three weights on one restoring divider. Queries over
// fewer handles, and the one-handle and zero-distance cases, finish sooner than a full query.
// The input stalls for the whole query. The result sits in an output register and the
// next transaction is taken while it waits, unless the receiver is stalling it; a finished
// query holds in the output state until that register is free. Handle entries that were never
// loaded read as anything. Weights are inverse-distance, Q0.16, saturated at 65535; status
// flags a query with no handles.
module nearest_three_bone_weights
  import ntbw_pkg::*;
#(
  parameter int unsigned MAX_HANDLES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [CntBits-1:0] cfg_data_i
);
  localparam int unsigned HBits  = (MAX_HANDLES > 1) ? $clog2(MAX_HANDLES) : 1;
  localparam int unsigned HcBits = $clog2(MAX_HANDLES + 1);
  localparam int unsigned DifBits = CoordBits + 1;
  localparam int unsigned SqBits = 2 * CoordBits + 2;
  localparam int unsigned RtBits = SqBits / 2;
  localparam int unsigned PBits  = 2 * RtBits + 2;

  typedef enum logic [7:0] {
    StIdle  = 8'b00000001,
    StRead  = 8'b00000010,
    StDist  = 8'b00000100,
    StSqrt  = 8'b00001000,
    StMul   = 8'b00010000,
    StDiv   = 8'b00100000,
    StOut   = 8'b01000000,
    StWait  = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic [CntBits-1:0] count_q;
  logic [HcBits-1:0]  lim_q;
  logic [HcBits-1:0]  h_q;
  logic [1:0]         m_q;
  logic [1:0]         k_q;
  logic               sub_q;

  logic [3*CoordBits-1:0] table_mem [MAX_HANDLES];
  logic [3*CoordBits-1:0] rd_q;
  logic signed [CoordBits-1:0] vx_q, vy_q, vz_q;

  logic [SqBits-1:0] bs_q [3];
  logic [HBits-1:0]  bi_q [3];
  logic [RtBits-1:0] dd_q [3];
  logic [PBits-1:0]  p_q  [3];
  logic [15:0]       w_q  [3];
  logic              out_v_q;
  out_item_t         out_q;

  // output register can take a new result this cycle
  logic out_free;
  assign out_free = !out_v_q || !out_stall_i;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle) || !out_free;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= '0;
    else if (cfg_valid_i) count_q <= cfg_data_i;
  end

  // table write on load, registered read during the scan
  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.cmd == CmdLoad && 32'(in_data_i.slot) < MAX_HANDLES)
      table_mem[HBits'(in_data_i.slot)] <= {in_data_i.pos_x, in_data_i.pos_y, in_data_i.pos_z};
    rd_q <= table_mem[h_q[HBits-1:0]];
  end

  // squared-distance unit
  logic signed [DifBits-1:0] dx, dy, dz;
  logic [DifBits-1:0] ax, ay, az;
  logic [2*DifBits-1:0] sx, sy, sz;
  logic [SqBits-1:0]  sq;
  always_comb begin
    dx = DifBits'(vx_q) - DifBits'($signed(rd_q[3*CoordBits-1 -: CoordBits]));
    dy = DifBits'(vy_q) - DifBits'($signed(rd_q[2*CoordBits-1 -: CoordBits]));
    dz = DifBits'(vz_q) - DifBits'($signed(rd_q[CoordBits-1:0]));
    ax = dx[DifBits-1] ? DifBits'(-dx) : DifBits'(dx);
    ay = dy[DifBits-1] ? DifBits'(-dy) : DifBits'(dy);
    az = dz[DifBits-1] ? DifBits'(-dz) : DifBits'(dz);
    sx = ax * ax;
    sy = ay * ay;
    sz = az * az;
    sq = sx + sy + sz;
  end

  // shared root and divider
  logic sq_start, sq_done, dv_start, dv_done;
  logic [RtBits-1:0] root;
  logic [15:0] quo;
  logic [PBits-1:0] dv_num, dv_den, psum;
  assign psum = p_q[0] + p_q[1] + p_q[2];
  assign dv_num = p_q[k_q];
  assign dv_den = psum;

  ntbw_sqrt #(.InBits(SqBits)) u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .val_i(bs_q[k_q]),
    .done_o(sq_done), .root_o(root));
  ntbw_frac #(.DBits(PBits)) u_frac (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .q_o(quo));

  // single multiplier for pair products
  logic [RtBits-1:0] ma, mb;
  logic [2*RtBits-1:0] prod;
  always_comb begin
    case (k_q)
      2'd0:    begin ma = dd_q[1]; mb = dd_q[2]; end
      2'd1:    begin ma = dd_q[0]; mb = dd_q[2]; end
      default: begin ma = dd_q[0]; mb = dd_q[1]; end
    endcase
  end
  assign prod = ma * mb;

  assign sq_start = (state_q == StSqrt) && !sub_q;
  assign dv_start = (state_q == StDiv) && !sub_q;

  function automatic logic lim_d_zero();
    return count_q == '0;
  endfunction

  // one handle or nearest at zero distance: full weight, no division
  function automatic logic sq_w_skip();
    return (m_q == 2'd1) || (dd_q[0] == '0);
  endfunction

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_acc && in_data_i.cmd == CmdQuery)
                 state_d = (lim_d_zero()) ? StOut : StRead;
      StRead:  state_d = StDist;
      StDist:  state_d = (h_q + 1'b1 >= lim_q) ? StSqrt : StRead;
      StSqrt:  if (sq_done && k_q == 2'd2) state_d = (m_q == 2'd3) ? StMul : StDiv;
      StMul:   if (k_q == 2'd2) state_d = StDiv;
      StDiv:   if (sq_w_skip() || (dv_done && k_q == m_q - 1'b1)) state_d = StOut;
      StOut:   if (out_free) state_d = StWait;
      StWait:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_v_q <= 1'b0;
      h_q <= '0; m_q <= '0; k_q <= '0; sub_q <= 1'b0; lim_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StOut && out_free) out_v_q <= 1'b1;
      else if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      case (state_q)
        StIdle: begin
          h_q <= '0; m_q <= '0; k_q <= '0; sub_q <= 1'b0;
          lim_q <= (32'(count_q) > MAX_HANDLES) ? HcBits'(MAX_HANDLES) : HcBits'(count_q);
        end
        StDist: begin
          h_q <= h_q + 1'b1;
          if (m_q != 2'd3) m_q <= m_q + 1'b1;
        end
        StSqrt: begin
          sub_q <= !sq_done;
          if (sq_done) k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 1'b1;
        end
        StMul: k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 1'b1;
        StDiv: begin
          sub_q <= !dv_done;
          if (dv_done) k_q <= k_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        vx_q <= in_data_i.pos_x; vy_q <= in_data_i.pos_y; vz_q <= in_data_i.pos_z;
        for (int i = 0; i < 3; i++) begin
          bs_q[i] <= '0; bi_q[i] <= '0; dd_q[i] <= '0; p_q[i] <= '0; w_q[i] <= '0;
        end
      end
      StDist: begin
        if (m_q < 2'd1 || sq < bs_q[0]) begin
          bs_q[2] <= bs_q[1]; bi_q[2] <= bi_q[1];
          bs_q[1] <= bs_q[0]; bi_q[1] <= bi_q[0];
          bs_q[0] <= sq;      bi_q[0] <= h_q[HBits-1:0];
        end else if (m_q < 2'd2 || sq < bs_q[1]) begin
          bs_q[2] <= bs_q[1]; bi_q[2] <= bi_q[1];
          bs_q[1] <= sq;      bi_q[1] <= h_q[HBits-1:0];
        end else if (m_q < 2'd3 || sq < bs_q[2]) begin
          bs_q[2] <= sq;      bi_q[2] <= h_q[HBits-1:0];
        end
      end
      StSqrt: if (sq_done) begin
        dd_q[k_q] <= root;
        // two kept: P0 = d1, P1 = d0
        if (k_q == 2'd0) p_q[1] <= PBits'(root);
        if (k_q == 2'd1) p_q[0] <= PBits'(root);
      end
      StMul: p_q[k_q] <= PBits'(prod);
      StDiv: begin
        if (sq_w_skip()) w_q[0] <= 16'hFFFF;
        else if (dv_done) w_q[k_q] <= quo;
      end
      StOut: if (out_free) begin
        out_q.idx_first     <= IdxBits'(bi_q[0]);
        out_q.idx_second    <= IdxBits'(bi_q[1]);
        out_q.idx_third     <= IdxBits'(bi_q[2]);
        out_q.weight_first  <= (m_q != '0 && sq_w_skip()) ? 16'hFFFF : w_q[0];
        out_q.weight_second <= w_q[1];
        out_q.weight_third  <= w_q[2];
        out_q.status        <= (m_q == '0);
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // no new transaction while a query is in flight
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o) else $error("accept while busy");
  // result appears only after the output state
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(state_q) == StOut) else $error("spurious result");
  // kept count never exceeds the number of handles searched so far
  a_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDist) |-> (32'(m_q) <= 32'(h_q))) else $error("kept count");
endmodule
